// ----- hw/rtl/skf_pkg.sv -----
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

  localparam int DATA_W     = 32;
  localparam int COV_W      = 31;
  localparam int DIFF_W     = DATA_W + 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 8'd3;

  localparam logic [COV_W-1:0]  RST_PROCESS_NOISE      = 31'd6554;
  localparam logic [COV_W-1:0]  RST_MEASUREMENT_NOISE  = 31'd6554;
  localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE   = 32'd0;
  localparam logic [COV_W-1:0]  RST_INITIAL_COVARIANCE = 31'd6554;

  localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul;
    logic upd;
  } skf_cmd_t;

  typedef struct packed {
    logic bypass;
    logic full_gain;
  } skf_stat_t;

endpackage

// ----- hw/rtl/skf_ctrl.sv -----
// Controller state machine that sequences one sample through the datapath.
module skf_ctrl #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  skf_pkg::skf_stat_t stat,
  output skf_pkg::skf_cmd_t  cmd
);

  localparam int CW = $clog2(GAIN_FRAC_BITS);
  localparam logic [CW-1:0] CNT_LAST = CW'(GAIN_FRAC_BITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_vld_r, out_vld_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt  = '0;
        priority if (stat.bypass) begin
          state_nxt = S_UPD;
        end else if (stat.full_gain) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!out_vld_r || out_ready) begin
          cmd.upd   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.upd) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;

endmodule

// ----- hw/rtl/skf_dp.sv -----
// Datapath: configuration registers, filter state, gain divider and multipliers.
module skf_dp #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic [skf_pkg::DATA_W-1:0]             in_measurement,
  input  logic                                   in_start_of_run,
  input  skf_pkg::skf_cmd_t                      cmd,
  output skf_pkg::skf_stat_t                     stat,
  output logic [skf_pkg::DATA_W-1:0]             out_filtered_value,
  output logic [GAIN_FRAC_BITS:0]                out_kalman_gain,
  output logic                                   out_fault
);

  localparam int DW  = skf_pkg::DATA_W;
  localparam int PW  = skf_pkg::COV_W;
  localparam int FW  = skf_pkg::DIFF_W;
  localparam int GW  = GAIN_FRAC_BITS + 1;
  localparam int SPW = FW + GW;
  localparam int CPW = PW + GW;
  localparam int SW  = DW + 2;
  localparam logic [GW-1:0] ONE_GAIN = GW'(1) << GAIN_FRAC_BITS;
  localparam logic [SW-1:0] EST_MAX  = SW'({1'b0, {(DW-1){1'b1}}});
  localparam logic [SW-1:0] EST_MIN  = {{3{1'b1}}, {(DW-1){1'b0}}};

  logic [PW-1:0] q_r, r_r, p0_r;
  logic [DW-1:0] x0_r;
  logic [DW-1:0] est_r;
  logic [PW-1:0] cov_r;
  logic          fault_r;

  logic [DW-1:0]  z_r;
  logic           sor_r;
  logic [PW-1:0]  p1_r;
  logic [DW-1:0]  den_r;
  logic [DW:0]    rem_r;
  logic [GW-1:0]  gain_r;
  logic [FW-1:0]  diff_r;
  logic           byp_r;
  logic           neg_r;
  logic [SPW-1:0] pstep_r;
  logic [CPW-1:0] pcov_r;
  logic [DW-1:0]  oest_r;
  logic [GW-1:0]  ogain_r;
  logic           ofault_r;

  logic [DW-1:0] est_w;
  logic [PW-1:0] cov_w;
  logic          fault_w;
  logic [DW-1:0] p1_sum;
  logic [PW-1:0] p1_w;
  logic [DW-1:0] den_w;
  logic          den_zero;
  logic [FW-1:0] diff_w;
  logic [DW:0]   rem2;
  logic          ge;
  logic [FW-1:0] mag;
  logic [FW-1:0] step;
  logic [SW-1:0] sum;
  logic [DW-1:0] est_new;
  logic [PW-1:0] cov_new;

  always_comb begin
    est_w    = sor_r ? x0_r : est_r;
    cov_w    = sor_r ? p0_r : cov_r;
    fault_w  = sor_r ? 1'b0 : fault_r;
    p1_sum   = {1'b0, cov_w} + {1'b0, q_r};
    p1_w     = p1_sum[DW-1] ? skf_pkg::COV_MAX : p1_sum[PW-1:0];
    den_w    = {1'b0, p1_w} + {1'b0, r_r};
    den_zero = (den_w == '0);
    diff_w   = {z_r[DW-1], z_r} - {est_w[DW-1], est_w};
    stat.bypass    = fault_w || den_zero;
    stat.full_gain = ({1'b0, p1_w} >= den_w);
  end

  always_comb begin
    rem2 = {rem_r[DW-1:0], 1'b0};
    ge   = (rem2 >= {1'b0, den_r});
    mag  = diff_r[FW-1] ? (FW'(0) - diff_r) : diff_r;
  end

  always_comb begin
    step = pstep_r[GAIN_FRAC_BITS +: FW];
    sum  = {est_r[DW-1], est_r[DW-1], est_r} +
           (neg_r ? (SW'(0) - {1'b0, step}) : {1'b0, step});
    priority if (sum[SW-1:DW-1] == '0 || sum[SW-1:DW-1] == '1) begin
      est_new = sum[DW-1:0];
    end else if (sum[SW-1]) begin
      est_new = EST_MIN[DW-1:0];
    end else begin
      est_new = EST_MAX[DW-1:0];
    end
    cov_new = pcov_r[GAIN_FRAC_BITS +: PW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r     <= skf_pkg::RST_PROCESS_NOISE;
      r_r     <= skf_pkg::RST_MEASUREMENT_NOISE;
      x0_r    <= skf_pkg::RST_INITIAL_ESTIMATE;
      p0_r    <= skf_pkg::RST_INITIAL_COVARIANCE;
      est_r   <= '0;
      cov_r   <= '0;
      fault_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          skf_pkg::REG_PROCESS_NOISE:      q_r  <= cfg_data[PW-1:0];
          skf_pkg::REG_MEASUREMENT_NOISE:  r_r  <= cfg_data[PW-1:0];
          skf_pkg::REG_INITIAL_ESTIMATE:   x0_r <= cfg_data[DW-1:0];
          skf_pkg::REG_INITIAL_COVARIANCE: p0_r <= cfg_data[PW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.prep) begin
        est_r   <= est_w;
        cov_r   <= cov_w;
        fault_r <= fault_w || den_zero;
      end else if (cmd.upd && !byp_r) begin
        est_r <= est_new;
        cov_r <= cov_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_r   <= in_measurement;
      sor_r <= in_start_of_run;
    end
    if (cmd.prep) begin
      p1_r   <= p1_w;
      den_r  <= den_w;
      rem_r  <= {2'b00, p1_w};
      diff_r <= diff_w;
      byp_r  <= stat.bypass;
      priority if (stat.bypass) begin
        gain_r <= '0;
      end else if (stat.full_gain) begin
        gain_r <= ONE_GAIN;
      end else begin
        gain_r <= '0;
      end
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? (rem2 - {1'b0, den_r}) : rem2;
      gain_r <= {gain_r[GW-2:0], ge};
    end
    if (cmd.mul) begin
      neg_r   <= diff_r[FW-1];
      pstep_r <= SPW'(mag) * SPW'(gain_r);
      pcov_r  <= CPW'(p1_r) * CPW'(ONE_GAIN - gain_r);
    end
    if (cmd.upd) begin
      oest_r   <= byp_r ? est_r : est_new;
      ogain_r  <= gain_r;
      ofault_r <= fault_r;
    end
  end

  assign out_filtered_value = oest_r;
  assign out_kalman_gain    = ogain_r;
  assign out_fault          = ofault_r;

endmodule

// ----- hw/rtl/scalar_kalman_filter.sv -----
// Top level of the scalar Kalman filter: controller, datapath and port packing.
//
// Measurements arrive on the in_ stream (tdata = signed Q16.16 sample, tuser =
// start of run) and one result leaves on the out_ stream for every input
// transfer (tdata = filtered estimate in the low 32 bits, then the Q1.16 gain;
// tuser = sticky fault). The cfg_ channel writes the four noise and initial
// value registers by index; it is always ready, and the user must write it only
// while idle; the block itself does not enforce this. In the general case a
// result passes through one setup step, one restoring divider step per gain
// bit (GAIN_FRAC_BITS steps), one multiply step and one update step. With
// unity gain the divider is skipped; in fault or with a zero denominator only
// setup and update run. The divider sets the sample rate: the block takes one
// sample at a time and accepts the next one in the cycle after the result has
// been moved into the output register.
// Reset restores the register defaults, clears estimate, covariance and fault,
// and empties the output register. When the receiver stalls, the result is held
// in the output register and the next sample waits in the update step.
module scalar_kalman_filter #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [31:0]                          in_tdata,   // measurement
  input  logic                                 in_tuser,   // start_of_run
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((32+GAIN_FRAC_BITS+1+7)/8)*8-1:0] out_tdata, // filtered_value, kalman_gain
  output logic                                 out_tuser,  // fault
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int OUT_W = ((32 + GAIN_FRAC_BITS + 1 + 7) / 8) * 8;

  skf_pkg::skf_cmd_t          cmd;
  skf_pkg::skf_stat_t         stat;
  logic [skf_pkg::DATA_W-1:0] filtered_value;
  logic [GAIN_FRAC_BITS:0]    kalman_gain;

  assign cfg_ready = 1'b1;

  skf_ctrl #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  skf_dp #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_measurement    (in_tdata),
    .in_start_of_run   (in_tuser),
    .cmd               (cmd),
    .stat              (stat),
    .out_filtered_value(filtered_value),
    .out_kalman_gain   (kalman_gain),
    .out_fault         (out_tuser)
  );

  assign out_tdata = OUT_W'({kalman_gain, filtered_value});

endmodule

// ----- hw/rtl/skf_checker.sv -----
// Port-level checker for the scalar Kalman filter and its bind statement.
module skf_checker #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input logic                                     clk,
  input logic                                     rst_n,
  input logic                                     out_tvalid,
  input logic                                     out_tready,
  input logic [((32+GAIN_FRAC_BITS+1+7)/8)*8-1:0] out_tdata,
  input logic                                     out_tuser
);

  localparam logic [GAIN_FRAC_BITS:0] ONE_GAIN = (GAIN_FRAC_BITS+1)'(1) << GAIN_FRAC_BITS;

  logic [GAIN_FRAC_BITS:0] gain;
  assign gain = out_tdata[32 +: GAIN_FRAC_BITS + 1];

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> gain <= ONE_GAIN)
    else $error("gain above one");

  a_fault_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> gain == '0)
    else $error("nonzero gain reported with fault");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind scalar_kalman_filter skf_checker #(
  .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
) u_skf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ----- verif/scalar_kalman_filter_test.sv -----
// Self-checking stream testbench for the scalar Kalman filter with its own predictor.
module scalar_kalman_filter_test;

  localparam int DATA_W = skf_pkg::DATA_W;
  localparam int COV_W = skf_pkg::COV_W;
  localparam int CFG_IDX_W = skf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = skf_pkg::CFG_DATA_W;
  localparam int GAIN_BITS = 16;
  localparam int OUT_W = ((DATA_W + GAIN_BITS + 1 + 7) / 8) * 8;
  localparam longint unsigned GAIN_ONE = 64'd1 << GAIN_BITS;
  localparam longint EST_HI = 64'sh7FFF_FFFF;
  localparam longint EST_LO = -EST_HI - 1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd4;
  localparam logic [DATA_W-1:0] Z_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Z_MIN = 32'h8000_0000;
  localparam int SETTLE_CYCLES = 25;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_SAMPLES = 96;

  typedef struct packed {
    logic [DATA_W-1:0] meas;
    logic              run_start;
  } sample_t;

  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic [GAIN_BITS:0] gain;
    logic               fault;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scalar_kalman_filter #(.GAIN_FRAC_BITS(GAIN_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Filter model: register copies and running state.
  logic [COV_W-1:0]         q_noise = skf_pkg::RST_PROCESS_NOISE;
  logic [COV_W-1:0]         r_noise = skf_pkg::RST_MEASUREMENT_NOISE;
  logic signed [DATA_W-1:0] est_init = skf_pkg::RST_INITIAL_ESTIMATE;
  logic [COV_W-1:0]         cov_init = skf_pkg::RST_INITIAL_COVARIANCE;
  logic signed [DATA_W-1:0] est = '0;
  logic [COV_W-1:0]         cov = '0;
  logic                     fault_held = 1'b0;

  sample_t sample_queue[$];
  result_t pending_results[$];
  result_t want;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int in_gap = 0;
  int out_gap = 0;
  int samples_queued = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned gain_quotient(longint unsigned num,
                                                    longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    int i;
    rem = num;
    quo = 0;
    if (rem >= den) return GAIN_ONE;
    for (i = 0; i < GAIN_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  function automatic longint unsigned scale_by_gain(longint unsigned a, longint unsigned g);
    return (a >> GAIN_BITS) * g + (((a & (GAIN_ONE - 1)) * g) >> GAIN_BITS);
  endfunction

  function automatic void kalman_predict(logic [DATA_W-1:0] z_bits, logic run_start);
    longint z;
    longint diff;
    longint nxt;
    longint unsigned p1;
    longint unsigned den;
    longint unsigned g;
    result_t res;
    z = longint'($signed(z_bits));
    g = 0;
    if (run_start) begin
      est = est_init;
      cov = cov_init;
      fault_held = 1'b0;
    end
    if (!fault_held) begin
      p1 = longint'(cov) + longint'(q_noise);
      if (p1 > skf_pkg::COV_MAX) p1 = skf_pkg::COV_MAX;
      den = p1 + r_noise;
      if (den == 0) begin
        fault_held = 1'b1;
      end else begin
        g = gain_quotient(p1, den);
        diff = z - longint'(est);
        if (diff < 0) nxt = longint'(est) - longint'(scale_by_gain(-diff, g));
        else nxt = longint'(est) + longint'(scale_by_gain(diff, g));
        if (nxt > EST_HI) nxt = EST_HI;
        if (nxt < EST_LO) nxt = EST_LO;
        est = nxt[DATA_W-1:0];
        cov = COV_W'(scale_by_gain(p1, GAIN_ONE - g));
      end
    end
    res.value = est;
    res.gain = g[GAIN_BITS:0];
    res.fault = fault_held;
    pending_results.push_back(res);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      skf_pkg::REG_PROCESS_NOISE: q_noise = data[COV_W-1:0];
      skf_pkg::REG_MEASUREMENT_NOISE: r_noise = data[COV_W-1:0];
      skf_pkg::REG_INITIAL_ESTIMATE: est_init = data[DATA_W-1:0];
      skf_pkg::REG_INITIAL_COVARIANCE: cov_init = data[COV_W-1:0];
      default: ;
    endcase
  endfunction

  // Sample sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        kalman_predict(in_tdata, in_tuser);
        samples_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (in_idle_on && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 8);
          in_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          sample_t s;
          s = sample_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= s.meas;
          in_tuser <= s.run_start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: filtered_value %h", out_tdata[DATA_W-1:0]);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[DATA_W-1:0] !== want.value) begin
            $error("filtered_value: expected %h, got %h", want.value, out_tdata[DATA_W-1:0]);
            mismatches++;
          end
          if (out_tdata[DATA_W+GAIN_BITS:DATA_W] !== want.gain) begin
            $error("kalman_gain: expected %h, got %h", want.gain,
                   out_tdata[DATA_W+GAIN_BITS:DATA_W]);
            mismatches++;
          end
          if (out_tuser !== want.fault) begin
            $error("fault: expected %b, got %b", want.fault, out_tuser);
            mismatches++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic queue_sample(input logic [DATA_W-1:0] z, input logic run_start);
    sample_t s;
    s.meas = z;
    s.run_start = run_start;
    sample_queue.push_back(s);
    samples_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (samples_sent != samples_queued || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_noise();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 255);
      3: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return Z_MAX;
      1: return Z_MIN;
      2, 3: return $urandom_range(0, 1 << 21) - (1 << 20);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int ph;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults, starting from the cleared state without a run start.
    queue_sample(32'h0001_0000, 1'b0);
    queue_sample(Z_MAX, 1'b0);
    queue_sample(Z_MIN, 1'b0);
    queue_sample('0, 1'b1);
    queue_sample('1, 1'b0);
    wait_drained();

    // All noise and covariance zero: zero denominator, held fault, fault again on restart.
    write_reg(skf_pkg::REG_PROCESS_NOISE, '0);
    write_reg(skf_pkg::REG_MEASUREMENT_NOISE, '0);
    write_reg(skf_pkg::REG_INITIAL_COVARIANCE, '0);
    write_reg(skf_pkg::REG_INITIAL_ESTIMATE, Z_MAX);
    cfg_valid <= 1'b0;
    queue_sample(Z_MIN, 1'b1);
    queue_sample('0, 1'b0);
    queue_sample(32'd1, 1'b1);
    wait_drained();

    // Zero measurement noise gives unity gain, then the covariance collapses into a fault.
    write_reg(skf_pkg::REG_INITIAL_COVARIANCE, 32'h100);
    write_reg(skf_pkg::REG_INITIAL_ESTIMATE, Z_MIN);
    cfg_valid <= 1'b0;
    queue_sample(Z_MAX, 1'b1);
    queue_sample('0, 1'b0);
    queue_sample('0, 1'b0);
    wait_drained();

    // Full-scale registers with the unused top bit set, and a write to an unused index.
    write_reg(skf_pkg::REG_PROCESS_NOISE, '1);
    write_reg(skf_pkg::REG_MEASUREMENT_NOISE, '1);
    write_reg(skf_pkg::REG_INITIAL_COVARIANCE, '1);
    write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, {CFG_IDX_W{1'b1}})), $urandom);
    cfg_valid <= 1'b0;
    queue_sample(Z_MAX, 1'b1);
    queue_sample(Z_MIN, 1'b0);
    queue_sample(32'h1234_5678, 1'b0);
    queue_sample(32'hFFFF_0000, 1'b1);
    wait_drained();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(skf_pkg::REG_PROCESS_NOISE, rand_noise());
      write_reg(skf_pkg::REG_MEASUREMENT_NOISE, rand_noise());
      write_reg(skf_pkg::REG_INITIAL_ESTIMATE, rand_value());
      write_reg(skf_pkg::REG_INITIAL_COVARIANCE, rand_noise());
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, {CFG_IDX_W{1'b1}})), $urandom);
      cfg_valid <= 1'b0;
      in_idle_on = (ph != 3) && (ph != RANDOM_PHASES - 1);
      out_idle_on = in_idle_on;
      for (n = 0; n < PHASE_SAMPLES; n++)
        queue_sample(rand_value(), n == 0 || $urandom_range(0, 11) == 0);
      wait_drained();
    end

    $display("Checked %0d results from %0d samples after %0d register writes,",
             results_seen, samples_sent, reg_writes);
    $display("covering faults, unity gain, full-scale registers and random runs.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
